// ===== rtl/core/rational_arithmetic_unit_assert.svh =====
// Assertion macros for the rational arithmetic unit.
// Depends on nothing; expects clk and arst_n in the including module.
`ifndef RATIONAL_ARITHMETIC_UNIT_ASSERT_SVH
`define RATIONAL_ARITHMETIC_UNIT_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define RAU_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked out of reset.
`define RAU_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/rau_pkg.sv =====
// Shared types and codes for the rational arithmetic unit.
// No dependencies.
`default_nettype none
package rau_pkg;
	localparam int FIELD_W = 32;
	localparam int DEN_W   = 31;

	// opcodes
	localparam logic [2:0] MODE_ADD = 3'd0;
	localparam logic [2:0] MODE_SUB = 3'd1;
	localparam logic [2:0] MODE_MUL = 3'd2;
	localparam logic [2:0] MODE_DIV = 3'd3;
	localparam logic [2:0] MODE_NEG = 3'd4;
	localparam logic [2:0] MODE_CMP = 3'd5;

	// status codes
	localparam logic [1:0] STAT_OK   = 2'd0;
	localparam logic [1:0] STAT_ZDEN = 2'd1;
	localparam logic [1:0] STAT_OVF  = 2'd2;

	// compare results
	localparam logic [1:0] ORD_LT = 2'b11;
	localparam logic [1:0] ORD_EQ = 2'b00;
	localparam logic [1:0] ORD_GT = 2'b01;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MUL_1,
		ST_MUL_2,
		ST_MUL_3,
		ST_SUM,
		ST_GCD_GO,
		ST_GCD_WAIT,
		ST_DIVN_GO,
		ST_DIVN_WAIT,
		ST_DIVD_GO,
		ST_DIVD_WAIT,
		ST_DONE
	} state_t;
endpackage
`default_nettype wire

// ===== rtl/core/rau_mul.sv =====
// Registered unsigned multiplier shared by all cross products.
// No dependencies.
`default_nettype none
module rau_mul #(
	parameter int W = 32
) (
	input  wire logic           clk,
	input  wire logic [W-1:0]   op_a,
	input  wire logic [W-1:0]   op_b,
	output logic      [2*W-1:0] prod_s1
);
	// one product per cycle, registered
	always_ff @(posedge clk) begin
		prod_s1 <= (2*W)'(op_a) * (2*W)'(op_b);
	end
endmodule
`default_nettype wire

// ===== rtl/core/rau_gcd.sv =====
// Binary gcd of two nonzero magnitudes, one subtract or shift per cycle.
// No dependencies.
`default_nettype none
module rau_gcd #(
	parameter int DW = 64
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	input  wire logic [DW-1:0] x,
	input  wire logic [DW-1:0] y,
	output logic               done,
	output logic      [DW-1:0] g
);
	localparam int KW = $clog2(DW + 1);

	logic          run_q, done_q;
	logic [DW-1:0] x_q, y_q, g_q;
	logic [KW-1:0] k_q;
	logic          finish;

	assign finish = run_q && (x_q == y_q);

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= finish;
			if (start) begin
				run_q <= 1'b1;
			end else if (finish) begin
				run_q <= 1'b0;
			end
		end
	end

	// datapath: strip common twos, then odd-odd subtract
	always_ff @(posedge clk) begin
		if (start) begin
			x_q <= x;
			y_q <= y;
			k_q <= '0;
		end else if (finish) begin
			g_q <= x_q << k_q;
		end else if (run_q) begin
			priority if (!x_q[0] && !y_q[0]) begin
				x_q <= x_q >> 1;
				y_q <= y_q >> 1;
				k_q <= k_q + KW'(1);
			end else if (!x_q[0]) begin
				x_q <= x_q >> 1;
			end else if (!y_q[0]) begin
				y_q <= y_q >> 1;
			end else if (x_q > y_q) begin
				x_q <= x_q - y_q;
			end else begin
				y_q <= y_q - x_q;
			end
		end
	end

	assign done = done_q;
	assign g    = g_q;
endmodule
`default_nettype wire

// ===== rtl/core/rau_div.sv =====
// Restoring divider, one quotient bit per cycle.
// No dependencies.
`default_nettype none
module rau_div #(
	parameter int DW = 64
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	input  wire logic [DW-1:0] dvd,
	input  wire logic [DW-1:0] dvs,
	output logic               done,
	output logic      [DW-1:0] quo
);
	localparam int CW = $clog2(DW + 1);

	logic          run_q, done_q;
	logic [DW-1:0] rem_q, quo_q, dvs_q;
	logic [CW-1:0] cnt_q;
	logic [DW:0]   trial;
	logic          take;
	logic          last;

	assign trial = {rem_q, quo_q[DW-1]};
	assign take  = trial >= {1'b0, dvs_q};
	assign last  = run_q && (cnt_q == CW'(DW - 1));

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= last;
			if (start) begin
				run_q <= 1'b1;
			end else if (last) begin
				run_q <= 1'b0;
			end
		end
	end

	// shift-subtract datapath; quotient bits replace dividend bits
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dvd;
			dvs_q <= dvs;
			cnt_q <= '0;
		end else if (run_q) begin
			rem_q <= take ? DW'(trial - {1'b0, dvs_q}) : trial[DW-1:0];
			quo_q <= {quo_q[DW-2:0], take};
			cnt_q <= cnt_q + CW'(1);
		end
	end

	assign done = done_q;
	assign quo  = quo_q;
endmodule
`default_nettype wire

// ===== rtl/core/rational_arithmetic_unit.sv =====
// An error or unused opcode caught at entry goes straight to the done state; compare or a
// zero result goes to done after the sum; else the gcd loop and two divisions come first.
// One word at a time: busy stays high from accept to the result strobe.
// Most time goes to the gcd loop and the divider; the multiplier runs in the ST_MUL states.
// Reset (arst_n low) returns the sequencer to idle and drops busy and done at once.
// The receiver cannot stall: each result is shown for exactly one cycle.
`default_nettype none
`include "rational_arithmetic_unit_assert.svh"
module rational_arithmetic_unit #(
	parameter int WIDTH = 32
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               start,
	output logic                                    busy,
	input  wire logic [2:0]                         mode,
	input  wire logic signed [rau_pkg::FIELD_W-1:0] a_num,
	input  wire logic signed [rau_pkg::FIELD_W-1:0] a_den,
	input  wire logic signed [rau_pkg::FIELD_W-1:0] b_num,
	input  wire logic signed [rau_pkg::FIELD_W-1:0] b_den,
	output logic                                    done,
	output logic signed [rau_pkg::FIELD_W-1:0]      res_num,
	output logic        [rau_pkg::DEN_W-1:0]        res_den,
	output logic signed [1:0]                       order,
	output logic        [1:0]                       status
);
	import rau_pkg::*;

	localparam int DW = 2 * WIDTH;
	localparam logic [DW-1:0] LIM = DW'(1) << (WIDTH - 1);

	state_t state_q, state_d;

	logic [2:0]       mode_q;
	logic [WIDTH-1:0] an_q, ad_q, bn_q, bd_q;
	logic             n1_q, n2_q;
	logic [DW-1:0]    m1_q, m2_q, num_q, den_q;
	logic             neg_q, zero_q;
	logic [1:0]       stat_q, ord_q;

	logic                    done_q;
	logic [FIELD_W-1:0]      res_num_q;
	logic [DEN_W-1:0]        res_den_q;
	logic [1:0]              res_ord_q, res_stat_q;

	// entry decode on the raw fields
	logic [WIDTH-1:0] an_m, ad_m, bn_m, bd_m;
	logic             sa, sb, accept, bad_op, zden, early;

	function automatic logic [WIDTH-1:0] mag(input logic [FIELD_W-1:0] v);
		logic [WIDTH-1:0] w;
		w = v[WIDTH-1:0];
		return w[WIDTH-1] ? WIDTH'(-w) : w;
	endfunction

	assign an_m   = mag(a_num);
	assign ad_m   = mag(a_den);
	assign bn_m   = mag(b_num);
	assign bd_m   = mag(b_den);
	assign sa     = a_num[WIDTH-1] ^ a_den[WIDTH-1];
	assign sb     = b_num[WIDTH-1] ^ b_den[WIDTH-1];
	assign accept = start && (state_q == ST_IDLE);
	assign bad_op = mode > MODE_CMP;
	assign zden   = (ad_m == '0) || ((mode != MODE_NEG) && (bd_m == '0))
		|| ((mode == MODE_DIV) && (bn_m == '0));
	assign early  = bad_op || zden;

	// shared units
	logic [WIDTH-1:0] op_a, op_b;
	logic [DW-1:0]    prod;
	logic             gcd_start, gcd_done, div_start, div_done;
	logic [DW-1:0]    gcd_g, div_quo, div_dvd;

	rau_mul #(.W(WIDTH)) u_mul (
		.clk     (clk),
		.op_a    (op_a),
		.op_b    (op_b),
		.prod_s1 (prod)
	);

	rau_gcd #(.DW(DW)) u_gcd (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (gcd_start),
		.x      (num_q),
		.y      (den_q),
		.done   (gcd_done),
		.g      (gcd_g)
	);

	rau_div #(.DW(DW)) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.dvd    (div_dvd),
		.dvs    (gcd_g),
		.done   (div_done),
		.quo    (div_quo)
	);

	// signed sum of the two cross products
	logic          sum_neg;
	logic [DW-1:0] sum_mag;
	always_comb begin
		if (n1_q == n2_q) begin
			sum_neg = n1_q;
			sum_mag = m1_q + m2_q;
		end else if (m1_q >= m2_q) begin
			sum_neg = (m1_q == m2_q) ? 1'b0 : n1_q;
			sum_mag = m1_q - m2_q;
		end else begin
			sum_neg = n2_q;
			sum_mag = m2_q - m1_q;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:      if (start) state_d = early ? ST_DONE : ST_MUL_1;
			ST_MUL_1:     state_d = ST_MUL_2;
			ST_MUL_2:     state_d = ST_MUL_3;
			ST_MUL_3:     state_d = ST_SUM;
			ST_SUM:       state_d = ((mode_q == MODE_CMP) || (sum_mag == '0))
				? ST_DONE : ST_GCD_GO;
			ST_GCD_GO:    state_d = ST_GCD_WAIT;
			ST_GCD_WAIT:  if (gcd_done) state_d = ST_DIVN_GO;
			ST_DIVN_GO:   state_d = ST_DIVN_WAIT;
			ST_DIVN_WAIT: if (div_done) state_d = ST_DIVD_GO;
			ST_DIVD_GO:   state_d = ST_DIVD_WAIT;
			ST_DIVD_WAIT: if (div_done) state_d = ST_DONE;
			ST_DONE:      state_d = ST_IDLE;
			default:      state_d = ST_IDLE;
		endcase
	end

	// sequencer outputs: multiplier operands and unit starts
	always_comb begin
		op_a      = '0;
		op_b      = '0;
		gcd_start = 1'b0;
		div_start = 1'b0;
		div_dvd   = den_q;
		unique case (state_q)
			ST_MUL_1: begin
				op_a = an_q;
				op_b = (mode_q == MODE_MUL) ? bn_q
					: (mode_q == MODE_NEG) ? WIDTH'(1) : bd_q;
			end
			ST_MUL_2: begin
				op_a = ((mode_q == MODE_ADD) || (mode_q == MODE_SUB)
					|| (mode_q == MODE_CMP)) ? bn_q : '0;
				op_b = ad_q;
			end
			ST_MUL_3: begin
				op_a = ad_q;
				op_b = (mode_q == MODE_DIV) ? bn_q
					: (mode_q == MODE_NEG) ? WIDTH'(1) : bd_q;
			end
			ST_GCD_GO:  gcd_start = 1'b1;
			ST_DIVN_GO: begin
				div_start = 1'b1;
				div_dvd   = num_q;
			end
			ST_DIVD_GO: div_start = 1'b1;
			default: ;
		endcase
	end

	// state register and result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= (state_q == ST_DONE);
		end
	end

	// overflow check on the reduced result
	logic             ovf;
	logic [WIDTH-1:0] num_w;
	assign ovf   = (den_q >= LIM) || (neg_q ? (num_q > LIM) : (num_q >= LIM));
	assign num_w = neg_q ? WIDTH'(-num_q[WIDTH-1:0]) : num_q[WIDTH-1:0];

	// operand, intermediate and result registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: if (accept) begin
				mode_q <= mode;
				an_q   <= an_m;
				ad_q   <= ad_m;
				bn_q   <= bn_m;
				bd_q   <= bd_m;
				n1_q   <= ((mode == MODE_MUL) || (mode == MODE_DIV)) ? (sa ^ sb)
					: (sa ^ (mode == MODE_NEG));
				n2_q   <= sb ^ ((mode == MODE_SUB) || (mode == MODE_CMP));
				stat_q <= (!bad_op && zden) ? STAT_ZDEN : STAT_OK;
				zero_q <= early;
				ord_q  <= ORD_EQ;
			end
			ST_MUL_2: m1_q <= prod;
			ST_MUL_3: m2_q <= prod;
			ST_SUM: begin
				den_q  <= prod;
				num_q  <= sum_mag;
				neg_q  <= sum_neg;
				zero_q <= (mode_q == MODE_CMP) || (sum_mag == '0);
				if (mode_q == MODE_CMP) begin
					ord_q <= (sum_mag == '0) ? ORD_EQ : (sum_neg ? ORD_LT : ORD_GT);
				end
			end
			ST_DIVN_WAIT: if (div_done) num_q <= div_quo;
			ST_DIVD_WAIT: if (div_done) den_q <= div_quo;
			ST_DONE: begin
				res_ord_q <= ord_q;
				if (zero_q || (stat_q != STAT_OK) || ovf) begin
					res_num_q  <= '0;
					res_den_q  <= DEN_W'(1);
					res_stat_q <= (!zero_q && (stat_q == STAT_OK)) ? STAT_OVF : stat_q;
				end else begin
					res_num_q  <= FIELD_W'($signed(num_w));
					res_den_q  <= DEN_W'(den_q[WIDTH-2:0]);
					res_stat_q <= STAT_OK;
				end
			end
			default: ;
		endcase
	end

	assign busy    = (state_q != ST_IDLE);
	assign done    = done_q;
	assign res_num = res_num_q;
	assign res_den = res_den_q;
	assign order   = res_ord_q;
	assign status  = res_stat_q;

	// checks
	`RAU_ASSERT_NEXT(a_accept_busy, accept, busy, "accepted word did not raise busy")
	`RAU_ASSERT_NOW(a_done_idle, done, !busy, "result strobe while still busy")
	`RAU_ASSERT_NOW(a_err_zero, done && (status != STAT_OK),
		(res_num == '0) && (res_den == DEN_W'(1)), "error result is not 0/1")
	`RAU_ASSERT_NOW(a_ord_only_ok, done && (order != ORD_EQ),
		(status == STAT_OK) && (res_num == '0), "order set on a non-compare result")
endmodule
`default_nettype wire

// ===== tb/rational_arithmetic_unit_test.sv =====
// Self-checking testbench for the rational arithmetic unit.
// Depends on rau_pkg and the rational_arithmetic_unit RTL; drives random and corner fractions.
`timescale 1ns / 1ps
`default_nettype none

// Holds the expected fraction results in arrival order and counts mismatches.
class fraction_scoreboard;
	typedef struct {
		logic signed [31:0] num;
		logic [30:0]        den;
		logic signed [1:0]  ord;
		logic [1:0]         stat;
	} frac_word_t;

	frac_word_t expected_q[$];
	int         mismatches;
	int         words_checked;

	// Magnitude and sign of a 32-bit two's complement field.
	static function logic [63:0] mag_of(logic [31:0] v, output bit neg);
		neg = v[31];
		return neg ? {32'd0, (~v + 32'd1)} : {32'd0, v};
	endfunction

	static function logic [63:0] gcd64(logic [63:0] x, logic [63:0] y);
		logic [63:0] t;
		while (y != 0) begin
			t = x % y;
			x = y;
			y = t;
		end
		return x;
	endfunction

	// Reduce sign-magnitude fraction with nonzero denominator.
	static function void shrink(inout bit neg, inout logic [63:0] n, inout logic [63:0] d);
		logic [63:0] g;
		if (n == 0) begin
			neg = 0;
			d = 1;
			return;
		end
		g = gcd64(n, d);
		n = n / g;
		d = d / g;
	endfunction

	function void note_input(logic [2:0] op, logic [31:0] an, logic [31:0] ad,
			logic [31:0] bn, logic [31:0] bd);
		frac_word_t  w;
		bit          san, sad, sbn, sbd, rn, fine, ln, gn, bneg;
		logic [63:0] man, mad, mbn, mbd, rnum, rden, l, g;
		man = mag_of(an, san);
		mad = mag_of(ad, sad);
		mbn = mag_of(bn, sbn);
		mbd = mag_of(bd, sbd);
		w.ord = rau_pkg::ORD_EQ;
		w.stat = rau_pkg::STAT_OK;
		rn = 0;
		rnum = 0;
		rden = 1;
		fine = 0;
		if (op <= rau_pkg::MODE_CMP) begin
			if (mad == 0 || (op != rau_pkg::MODE_NEG && mbd == 0)) begin
				w.stat = rau_pkg::STAT_ZDEN;
			end else begin
				san = san ^ sad;
				shrink(san, man, mad);
				sbn = sbn ^ sbd;
				if (op != rau_pkg::MODE_NEG) shrink(sbn, mbn, mbd);
				case (op)
					rau_pkg::MODE_ADD, rau_pkg::MODE_SUB: begin
						bneg = (op == rau_pkg::MODE_SUB) ? (mbn != 0 && !sbn) : sbn;
						l = man * mbd;
						g = mbn * mad;
						if (san == bneg) begin
							rn = san;
							rnum = l + g;
						end else if (l >= g) begin
							rn = (l == g) ? 0 : san;
							rnum = l - g;
						end else begin
							rn = bneg;
							rnum = g - l;
						end
						rden = mad * mbd;
						shrink(rn, rnum, rden);
						fine = 1;
					end
					rau_pkg::MODE_MUL: begin
						rn = san ^ sbn;
						rnum = man * mbn;
						rden = mad * mbd;
						shrink(rn, rnum, rden);
						fine = 1;
					end
					rau_pkg::MODE_DIV: begin
						if (mbn == 0) begin
							w.stat = rau_pkg::STAT_ZDEN;
						end else begin
							rn = san ^ sbn;
							rnum = man * mbd;
							rden = mad * mbn;
							shrink(rn, rnum, rden);
							fine = 1;
						end
					end
					rau_pkg::MODE_NEG: begin
						rn = (man != 0) && !san;
						rnum = man;
						rden = mad;
						fine = 1;
					end
					default: begin
						l = man * mbd;
						g = mbn * mad;
						ln = san && l != 0;
						gn = sbn && g != 0;
						if (ln != gn) w.ord = ln ? rau_pkg::ORD_LT : rau_pkg::ORD_GT;
						else if (l == g) w.ord = rau_pkg::ORD_EQ;
						else if (ln) w.ord = (l > g) ? rau_pkg::ORD_LT : rau_pkg::ORD_GT;
						else w.ord = (l > g) ? rau_pkg::ORD_GT : rau_pkg::ORD_LT;
					end
				endcase
				// Out-of-range results are flagged, never wrapped.
				if (fine && (rden > 64'h7FFF_FFFF ||
						rnum > (rn ? 64'h8000_0000 : 64'h7FFF_FFFF))) begin
					w.stat = rau_pkg::STAT_OVF;
					fine = 0;
				end
			end
		end
		if (!fine) begin
			rn = 0;
			rnum = 0;
			rden = 1;
		end
		w.num = rn ? (32'd0 - rnum[31:0]) : rnum[31:0];
		w.den = rden[30:0];
		expected_q.push_back(w);
	endfunction

	function void check_result(logic signed [31:0] num, logic [30:0] den,
			logic signed [1:0] ord, logic [1:0] stat);
		frac_word_t w;
		if (expected_q.size() == 0) begin
			mismatches++;
			if (mismatches <= 10) $display("unexpected result word %0d/%0d", num, den);
			return;
		end
		w = expected_q.pop_front();
		words_checked++;
		if (num !== w.num || den !== w.den || ord !== w.ord || stat !== w.stat) begin
			mismatches++;
			if (mismatches <= 10)
				$display("mismatch: exp %0d/%0d ord %0d st %0d, got %0d/%0d ord %0d st %0d",
					w.num, w.den, w.ord, w.stat, num, den, ord, stat);
		end
	endfunction
endclass

module rational_arithmetic_unit_test;
	import rau_pkg::*;

	logic                      clk;
	logic                      arst_n;
	logic                      start;
	logic                      busy;
	logic [2:0]                mode;
	logic signed [FIELD_W-1:0] a_num, a_den, b_num, b_den;
	logic                      done;
	logic signed [FIELD_W-1:0] res_num;
	logic [DEN_W-1:0]          res_den;
	logic signed [1:0]         order;
	logic [1:0]                status;

	fraction_scoreboard board = new();
	int burst_left;

	rational_arithmetic_unit #(.WIDTH(32)) u_top (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .mode(mode),
		.a_num(a_num), .a_den(a_den), .b_num(b_num), .b_den(b_den),
		.done(done), .res_num(res_num), .res_den(res_den), .order(order),
		.status(status)
	);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	// Results are taken at the edge that ends the strobe cycle.
	always @(posedge clk) begin
		if (arst_n && done) board.check_result(res_num, res_den, order, status);
	end

	// Present one word and hold it until the block accepts it.
	task automatic send_word(logic [2:0] op, logic [31:0] an, logic [31:0] ad,
			logic [31:0] bn, logic [31:0] bd);
		start <= 1;
		mode <= op;
		a_num <= an;
		a_den <= ad;
		b_num <= bn;
		b_den <= bd;
		do @(posedge clk); while (busy);
		board.note_input(op, an, ad, bn, bd);
		// Bursty sender: random gaps between bursts.
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			start <= 0;
			repeat ($urandom_range(1, 20)) @(posedge clk);
			burst_left = $urandom_range(0, 6);
		end
	endtask

	// Random field value: mostly small, sometimes full range or edge.
	function automatic logic [31:0] pick_field();
		case ($urandom_range(0, 9))
			0, 1, 2, 3: return $urandom_range(0, 40) - 20;
			4, 5: return $urandom_range(0, 2000) - 1000;
			6: return $urandom();
			7: return 32'h8000_0000 + $urandom_range(0, 3);
			8: return 32'h7FFF_FFFF - $urandom_range(0, 3);
			default: return $urandom_range(0, 65535) - 32768;
		endcase
	endfunction

	function automatic logic [31:0] pick_den();
		logic [31:0] v;
		v = pick_field();
		if (v == 0 && $urandom_range(0, 3) != 0) v = 1;
		return v;
	endfunction

	task automatic drain();
		start <= 0;
		while (board.expected_q.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	initial begin
		logic [2:0] op;
		arst_n = 0;
		start = 0;
		mode = 0;
		a_num = 0;
		a_den = 1;
		b_num = 0;
		b_den = 1;
		burst_left = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Directed corners: every opcode, zero denominators, extremes, overflow.
		for (int m = 0; m < 8; m++) send_word(3'(m), 3, -6, 5, 10);
		send_word(MODE_ADD, 1, 0, 1, 2);
		send_word(MODE_NEG, 1, 2, 1, 0);
		send_word(MODE_DIV, 1, 2, 0, 7);
		send_word(MODE_CMP, 1, 0, 1, 1);
		send_word(MODE_NEG, 32'h8000_0000, 1, 0, 1);
		send_word(MODE_NEG, 32'h8000_0000, -1, 0, 1);
		send_word(MODE_MUL, 32'h7FFF_FFFF, 1, 32'h7FFF_FFFF, 1);
		send_word(MODE_ADD, 32'h8000_0000, 1, 32'h8000_0000, 1);
		send_word(MODE_SUB, 5, 7, 5, 7);
		send_word(MODE_DIV, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000);
		send_word(MODE_CMP, -1, 3, 1, -3);
		send_word(MODE_CMP, 32'h8000_0000, 1, 32'h7FFF_FFFF, 1);
		send_word(MODE_ADD, 0, -5, 0, 32'h8000_0000);
		send_word(MODE_MUL, 1, 32'h7FFF_FFFF, 1, 2);
		// Sender waits for an empty pipeline at least once.
		drain();

		for (int i = 0; i < 550; i++) begin
			op = 3'(($urandom_range(0, 15) == 0) ? $urandom_range(6, 7)
				: $urandom_range(0, 5));
			send_word(op, pick_field(), pick_den(), pick_field(), pick_den());
			if (i == 275) drain();
		end
		drain();

		$display("checked %0d result words over all opcodes, zero denominators and overflow",
			board.words_checked);
		if (board.mismatches == 0) $display("simulation ok");
		else $display("simulation failed");
		$finish;
	end

	initial begin
		#20ms;
		$display("simulation failed");
		$finish;
	end
endmodule
`default_nettype wire
